// ===== rtl/wbg_pkg.sv =====
// Shared types and constants for the window brightness gradient block.
// No dependencies; every other file of the block refers to this package by scoped names.
`timescale 1ns / 1ps

package wbg_pkg;

  // fixed field and datapath widths
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned SCALE_W    = 24;
  localparam int unsigned DARK_W     = 32;
  localparam int unsigned COEF_W     = 17;
  localparam int unsigned MUL_A_W    = 32;
  localparam int unsigned MUL_B_W    = 25;
  localparam int unsigned MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int unsigned RES_W      = 32;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned ONE_Q16    = 65536;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 24;

  typedef logic [COEF_W-1:0]         coef_t;
  typedef logic signed [DARK_W-1:0]  dark_t;
  typedef logic signed [MUL_P_W-1:0] mul_prod_t;

  // operands of the shared multiplier
  typedef struct packed {
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_req_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 4'd0,
    CFG_IMAGE_HEIGHT = 4'd1,
    CFG_HALF_WINDOW  = 4'd2,
    CFG_PIXEL_SCALE  = 4'd3
  } cfg_idx_e;

  // item kinds carried in tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

// ===== rtl/window_brightness_gradient.sv =====
// Top level of the window brightness gradient block: stream ports, config, sequencer.
// Depends on wbg_pkg, wbg_img_ram, wbg_coef_rom, wbg_mul and wbg_div.
`timescale 1ns / 1ps

// A pixel write (tuser = 0) is taken and gives no result. A query (tuser = 1)
// walks the (2h+1)^2-1 window pixels one at a time through a single shared multiplier:
// each pixel passes through image read, darkness product, saturation, x and y weight
// products and accumulation. The two sums are then divided by the window count in a
// bit-serial divider of DivW = 34 + clog2(4*MAX_HALF_WINDOW*(MAX_HALF_WINDOW+1)+1) bits
// (43 at the default parameters), one bit per cycle for x and then for y. A query with
// h = 0 answers zero. The input and config ports are not ready while a query runs; one
// finished result may wait in the output register while the next item is taken. Pixels
// that were never written read as unknown values.
module window_brightness_gradient #(
  parameter int MAX_WIDTH       = 256,
  parameter int MAX_HEIGHT      = 256,
  parameter int MAX_HALF_WINDOW = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [9:0] pos_x, [19:10] pos_y, [27:20] pixel_value, [31:28] zero
  input  logic [31:0]                    s_axis_tdata_i,
  // [0] opcode
  input  logic [0:0]                     s_axis_tuser_i,
  // result stream
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [31:0] grad_x, [63:32] grad_y
  output logic [63:0]                    m_axis_tdata_o,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [wbg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wbg_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int HIW      = $clog2(MAX_HALF_WINDOW + 1);
  localparam int HSW      = HIW + 1;
  localparam int XW       = $clog2(MAX_WIDTH);
  localparam int YW       = $clog2(MAX_HEIGHT);
  localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW       = $clog2(DEPTH);
  localparam int CountMax = 4 * MAX_HALF_WINDOW * (MAX_HALF_WINDOW + 1);
  localparam int CNTW     = $clog2(CountMax + 1);
  localparam int SW       = 48 + CNTW;
  localparam int NW       = SW + 2 - wbg_pkg::FRAC_W;
  localparam int CSW      = 12;

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_DARK = 4'd2;
  localparam logic [3:0] S_SAT  = 4'd3;
  localparam logic [3:0] S_MX   = 4'd4;
  localparam logic [3:0] S_MY   = 4'd5;
  localparam logic [3:0] S_ACY  = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;
  localparam logic [3:0] S_DIVX = 4'd8;
  localparam logic [3:0] S_DIVY = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [3:0] state_q, state_d;

  // configuration registers
  logic [8:0]                      img_w_q;
  logic [8:0]                      img_h_q;
  logic [3:0]                      half_q;
  logic [wbg_pkg::SCALE_W-1:0]     scale_q;

  // query context
  logic signed [9:0]               px_q;
  logic signed [9:0]               py_q;
  logic signed [HSW-1:0]           i_q, j_q;
  logic signed [HSW-1:0]           ni, nj;
  wbg_pkg::dark_t                  d_q;
  logic signed [SW-1:0]            acc_x_q, acc_y_q;
  logic                            neg_x_q, neg_y_q;
  logic [wbg_pkg::RES_W-1:0]       res_x_q, res_y_q;
  logic [wbg_pkg::RES_W-1:0]       out_x_q, out_y_q;
  logic                            m_valid_q;

  // input fields
  logic                            in_opcode;
  logic signed [9:0]               in_pos_x;
  logic signed [9:0]               in_pos_y;
  logic [wbg_pkg::PIX_W-1:0]       in_pixel;
  logic                            in_acc;
  logic                            q_acc;
  logic                            wr_en;
  logic [AW-1:0]                   wr_addr;

  // effective configuration
  logic [8:0]                      w_eff;
  logic [8:0]                      hgt_eff;
  logic [HIW-1:0]                  h_eff;
  logic signed [HSW-1:0]           h_s;
  logic [CNTW-1:0]                 count;

  // window addressing
  logic signed [CSW-1:0]           xs, ys, xmax, ymax, xc, yc;
  logic [AW-1:0]                   rd_addr;
  logic [wbg_pkg::PIX_W-1:0]       pix;

  // weights and multiplier
  logic [HIW-1:0]                  i_abs, j_abs;
  logic [HIW-1:0]                  rom_a, rom_b;
  wbg_pkg::coef_t                  coef_mag;
  logic                            coef_neg;
  logic signed [wbg_pkg::MUL_B_W-1:0] coef_s;
  wbg_pkg::mul_req_t               mreq;
  wbg_pkg::mul_prod_t              prod;
  logic signed [33:0]              dark_full;
  wbg_pkg::dark_t                  dark_sat;
  logic                            last_pix;
  logic                            out_load;

  // final division
  logic signed [SW-1:0]            acc_sel;
  logic [SW+1:0]                   sum2;
  logic [SW+1:0]                   rnd;
  logic [SW+1:0]                   num;
  logic                            div_start;
  logic [NW-1:0]                   quot;
  wbg_pkg::div_stat_t              div_stat;

  // saturate a quotient magnitude with its sign to Q16.16
  function automatic logic [wbg_pkg::RES_W-1:0] sat_res(input logic [NW-1:0] q,
                                                          input logic neg);
    logic ovf;
    logic [wbg_pkg::RES_W-1:0] low;
    ovf = |q[NW-1:wbg_pkg::RES_W-1];
    low = q[wbg_pkg::RES_W-1:0];
    if (neg) begin
      sat_res = ovf ? 32'h8000_0000 : (32'd0 - low);
    end else begin
      sat_res = ovf ? 32'h7fff_ffff : low;
    end
  endfunction

  // input unpacking and handshake
  assign in_opcode       = s_axis_tuser_i[0];
  assign in_pos_x        = $signed(s_axis_tdata_i[9:0]);
  assign in_pos_y        = $signed(s_axis_tdata_i[19:10]);
  assign in_pixel        = s_axis_tdata_i[27:20];
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign cfg_ready_o     = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign q_acc           = in_acc && (in_opcode == wbg_pkg::OP_QUERY);

  // pixel write path, ignored outside the store
  assign wr_en   = in_acc && (in_opcode == wbg_pkg::OP_WRITE) &&
                   !in_pos_x[9] && (in_pos_x < MAX_WIDTH) &&
                   !in_pos_y[9] && (in_pos_y < MAX_HEIGHT);
  assign wr_addr = AW'(YW'($unsigned(in_pos_y))) * AW'(MAX_WIDTH) +
                   AW'(XW'($unsigned(in_pos_x)));

  // configuration write decode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= 9'd256;
      img_h_q <= 9'd256;
      half_q  <= 4'd2;
      scale_q <= 24'd257;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        wbg_pkg::CFG_IMAGE_WIDTH:  img_w_q <= cfg_data_i[8:0];
        wbg_pkg::CFG_IMAGE_HEIGHT: img_h_q <= cfg_data_i[8:0];
        wbg_pkg::CFG_HALF_WINDOW:  half_q  <= cfg_data_i[3:0];
        wbg_pkg::CFG_PIXEL_SCALE:  scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective sizes
  assign w_eff   = (img_w_q == 9'd0) ? 9'd1 :
                   (img_w_q > MAX_WIDTH) ? 9'(MAX_WIDTH) : img_w_q;
  assign hgt_eff = (img_h_q == 9'd0) ? 9'd1 :
                   (img_h_q > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : img_h_q;
  assign h_eff   = (half_q > MAX_HALF_WINDOW) ? HIW'(MAX_HALF_WINDOW) : HIW'(half_q);
  assign h_s     = $signed({1'b0, h_eff});
  assign count   = (CNTW'(h_eff) * (CNTW'(h_eff) + CNTW'(1))) << 2;

  // clamped window coordinates and read address
  assign xs   = CSW'(px_q) + CSW'(i_q);
  assign ys   = CSW'(py_q) + CSW'(j_q);
  assign xmax = $signed(CSW'(w_eff) - CSW'(1));
  assign ymax = $signed(CSW'(hgt_eff) - CSW'(1));
  assign xc   = xs[CSW-1] ? '0 : ((xs > xmax) ? xmax : xs);
  assign yc   = ys[CSW-1] ? '0 : ((ys > ymax) ? ymax : ys);
  assign rd_addr = AW'(YW'($unsigned(yc))) * AW'(MAX_WIDTH) + AW'(XW'($unsigned(xc)));

  wbg_img_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (in_pixel),
    .re_i    (state_q == S_RD),
    .raddr_i (rd_addr),
    .rdata_o (pix)
  );

  // weight lookup: x weight uses (|i|,|j|), y weight uses (|j|,|i|)
  assign i_abs    = i_q[HSW-1] ? HIW'(-i_q) : HIW'(i_q);
  assign j_abs    = j_q[HSW-1] ? HIW'(-j_q) : HIW'(j_q);
  assign rom_a    = (state_q == S_MY) ? j_abs : i_abs;
  assign rom_b    = (state_q == S_MY) ? i_abs : j_abs;
  assign coef_neg = (state_q == S_MY) ? j_q[HSW-1] : i_q[HSW-1];

  wbg_coef_rom #(
    .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
    .HIW             (HIW)
  ) u_rom (
    .a_i    (rom_a),
    .b_i    (rom_b),
    .coef_o (coef_mag)
  );

  assign coef_s = coef_neg ? -$signed(wbg_pkg::MUL_B_W'(coef_mag))
                           : $signed(wbg_pkg::MUL_B_W'(coef_mag));

  // shared multiplier operand select
  always_comb begin
    if (state_q == S_DARK) begin
      mreq.a = $signed(wbg_pkg::MUL_A_W'(pix));
      mreq.b = $signed(wbg_pkg::MUL_B_W'(scale_q));
    end else begin
      mreq.a = d_q;
      mreq.b = coef_s;
    end
  end

  wbg_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mreq),
    .prod_o (prod)
  );

  // darkness 1 - p * scale, saturated low
  assign dark_full = $signed(34'(wbg_pkg::ONE_Q16)) - $signed({1'b0, prod[32:0]});
  assign dark_sat  = ((dark_full[33:31] == 3'b000) || (dark_full[33:31] == 3'b111)) ?
                     dark_full[31:0] : 32'sh8000_0000;

  // next window offset, skipping the centre
  always_comb begin
    ni = i_q;
    nj = j_q;
    if (j_q == h_s) begin
      nj = -h_s;
      ni = i_q + HSW'(1);
    end else begin
      nj = j_q + HSW'(1);
    end
    if (ni == '0 && nj == '0) begin
      nj = HSW'(1);
    end
  end
  assign last_pix = (i_q == h_s) && (j_q == h_s);

  // rounding divide setup: (2|sum| + count*2^15) >> 16, then / count
  assign acc_sel   = (state_q == S_FIN) ? acc_x_q : acc_y_q;
  assign sum2      = {acc_sel[SW-1], acc_sel, 1'b0};
  assign rnd       = (SW+2)'(count) << (wbg_pkg::FRAC_W - 1);
  assign num       = acc_sel[SW-1] ? (rnd - sum2) : (rnd + sum2);
  assign div_start = (state_q == S_FIN) || ((state_q == S_DIVX) && div_stat.done);

  wbg_div #(
    .NUM_W (NW),
    .DEN_W (CNTW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (num[SW+1:wbg_pkg::FRAC_W]),
    .divisor_i  (count),
    .quotient_o (quot),
    .stat_o     (div_stat)
  );

  // sequencer next state
  assign out_load = (state_q == S_OUT) && (!m_valid_q || m_axis_tready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (q_acc) state_d = (h_eff == '0) ? S_OUT : S_RD;
      S_RD:   state_d = S_DARK;
      S_DARK: state_d = S_SAT;
      S_SAT:  state_d = S_MX;
      S_MX:   state_d = S_MY;
      S_MY:   state_d = S_ACY;
      S_ACY:  state_d = last_pix ? S_FIN : S_RD;
      S_FIN:  state_d = S_DIVX;
      S_DIVX: if (div_stat.done) state_d = S_DIVY;
      S_DIVY: if (div_stat.done) state_d = S_OUT;
      S_OUT:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      i_q       <= '0;
      j_q       <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (q_acc) begin
        i_q <= -h_s;
        j_q <= -h_s;
      end else if (state_q == S_ACY && !last_pix) begin
        i_q <= ni;
        j_q <= nj;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (q_acc) begin
      px_q    <= in_pos_x;
      py_q    <= in_pos_y;
      acc_x_q <= '0;
      acc_y_q <= '0;
      res_x_q <= '0;
      res_y_q <= '0;
    end
    if (state_q == S_SAT) begin
      d_q <= dark_sat;
    end
    if (state_q == S_MY) begin
      acc_x_q <= acc_x_q + SW'(prod);
    end
    if (state_q == S_ACY) begin
      acc_y_q <= acc_y_q + SW'(prod);
    end
    if (state_q == S_FIN) begin
      neg_x_q <= acc_x_q[SW-1];
      neg_y_q <= acc_y_q[SW-1];
    end
    if (state_q == S_DIVX && div_stat.done) begin
      res_x_q <= sat_res(quot, neg_x_q);
    end
    if (state_q == S_DIVY && div_stat.done) begin
      res_y_q <= sat_res(quot, neg_y_q);
    end
    if (out_load) begin
      out_x_q <= res_x_q;
      out_y_q <= res_y_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {out_y_q, out_x_q};

`ifndef SYNTH
  // the divider is only started when idle
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // a finished division is only seen while waiting on it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == S_DIVX || state_q == S_DIVY))
    else $error("divider result arrived outside a division state");

  // window offsets stay within the half size during a query
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (i_q >= -h_s) && (i_q <= h_s) && (j_q >= -h_s) && (j_q <= h_s))
    else $error("window offset out of range");

  // the centre pixel is never read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |-> !(i_q == '0 && j_q == '0))
    else $error("centre pixel visited");

  // a result is only presented after a finished query
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> ($past(state_q) == S_OUT))
    else $error("result presented without a finished query");
`endif

endmodule

// ===== rtl/wbg_img_ram.sv =====
// Image store: one write port, one read port with registered read data.
// Depends on wbg_pkg for the pixel width.
`timescale 1ns / 1ps

module wbg_img_ram #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [wbg_pkg::PIX_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [wbg_pkg::PIX_W-1:0] rdata_o
);

  logic [wbg_pkg::PIX_W-1:0] mem [DEPTH];
  logic [wbg_pkg::PIX_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/wbg_coef_rom.sv =====
// Constant weight table: round(65536 * a / (a*a + b*b)) in Q1.16, built at elaboration.
// Depends on wbg_pkg for the coefficient type.
`timescale 1ns / 1ps

module wbg_coef_rom #(
  parameter int MAX_HALF_WINDOW = 8,
  parameter int HIW             = 4
) (
  input  logic [HIW-1:0]      a_i,
  input  logic [HIW-1:0]      b_i,
  output wbg_pkg::coef_t      coef_o
);

  wbg_pkg::coef_t tab [MAX_HALF_WINDOW+1][MAX_HALF_WINDOW+1];

  // one entry per offset magnitude pair, halves rounded up
  for (genvar ga = 0; ga <= MAX_HALF_WINDOW; ga++) begin : g_a
    for (genvar gb = 0; gb <= MAX_HALF_WINDOW; gb++) begin : g_b
      localparam int Den  = (ga == 0 && gb == 0) ? 1 : ga * ga + gb * gb;
      localparam int Coef = (2 * wbg_pkg::ONE_Q16 * ga + Den) / (2 * Den);
      assign tab[ga][gb] = wbg_pkg::coef_t'(Coef);
    end
  end

  assign coef_o = tab[a_i][b_i];

endmodule

// ===== rtl/wbg_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on wbg_pkg for the operand struct and product type.
`timescale 1ns / 1ps

module wbg_mul (
  input  logic                clk_i,
  input  wbg_pkg::mul_req_t   req_i,
  output wbg_pkg::mul_prod_t  prod_o
);

  wbg_pkg::mul_prod_t prod_q;

  // one product per cycle
  always_ff @(posedge clk_i) begin
    prod_q <= wbg_pkg::mul_prod_t'(req_i.a) * wbg_pkg::mul_prod_t'(req_i.b);
  end

  assign prod_o = prod_q;

endmodule

// ===== rtl/wbg_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on wbg_pkg for the status struct.
`timescale 1ns / 1ps

module wbg_div #(
  parameter int NUM_W = 44,
  parameter int DEN_W = 9
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NUM_W-1:0]    dividend_i,
  input  logic [DEN_W-1:0]    divisor_i,
  output logic [NUM_W-1:0]    quotient_o,
  output wbg_pkg::div_stat_t  stat_o
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CW-1:0]    cnt_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] dvs_q;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [DEN_W-1:0] rem_n;

  // one restoring step
  assign rem_sh = {rem_q, quo_q[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign rem_n  = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];

  // step counter and status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient and remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], ge};
      rem_q <= rem_n;
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule
